### rtl/tms_pkg.sv
`timescale 1ns / 1ps

package tms_pkg;

    // tape and rule table sizing
    localparam int TAPE_DEPTH  = 4096;
    localparam int STATE_COUNT = 32;

    // field widths
    localparam int STATE_W  = 5;
    localparam int INDEX_W  = 5;
    localparam int WORD_W   = 16;
    localparam int OP_W     = 2;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 1;

    // derived widths
    localparam int HEAD_W     = $clog2(TAPE_DEPTH);
    localparam int LEN_W      = $clog2(TAPE_DEPTH + 1);
    localparam int DIV_W      = LEN_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int RULE_DEPTH = 2 ** STATE_W;

    // input operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_STEP    = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAPE_LENGTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE = 1'd1;

    // action byte layout
    localparam int ACT_WRITE_BIT = 0;
    localparam int ACT_MOVE_BIT  = 1;
    localparam int ACT_STATE_LSB = 2;

endpackage

### rtl/tms_ram.sv
`timescale 1ns / 1ps

module tms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tms_mod.sv
`timescale 1ns / 1ps

module tms_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tms_pkg::DIV_W-1:0]  i_dividend,
    input  logic [tms_pkg::LEN_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [tms_pkg::HEAD_W-1:0] o_rem
);
    import tms_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_num;
    logic [DIV_W-1:0]     r_rem;
    logic [LEN_W-1:0]     r_div;
    logic [DIV_W-1:0]     n_shift;
    logic [DIV_W-1:0]     n_rem;

    // one restoring remainder step: shift in a bit, subtract if it fits
    always_comb begin
        n_shift = {r_rem[DIV_W-2:0], r_num[DIV_W-1]};
        if (n_shift >= DIV_W'(r_div)) begin
            n_rem = n_shift - DIV_W'(r_div);
        end else begin
            n_rem = n_shift;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[HEAD_W-1:0];

endmodule

### rtl/turing_machine_stepper_unit.sv
`timescale 1ns / 1ps

// channel   direction  signals                                          transfer when
// in        to block   i_in_valid o_in_ready i_op i_rule_index i_rule_word  valid & ready
// out       from block o_out_valid i_out_ready o_current_state
//                      o_head_position o_ones_count                     valid & ready
// cfg       to block   i_cfg_valid o_cfg_ready i_cfg_index i_cfg_data   valid & ready
//
// load, restart and no-op items complete in the idle state; a step reads the tape and rule
// memory, then writes back in the act state, and goes on through the remainder unit
// when the head sits at or beyond the tape length.
// after reset the tape memory is cleared cell by cell over all TAPE_DEPTH cells; a
// restart with ones on the tape runs the same clear before the next item is taken.
// one item is in flight at a time; a new item is taken once the output register is
// empty or being drained. cfg writes are always taken.

module turing_machine_stepper_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tms_pkg::OP_W-1:0]      i_op,
    input  logic [tms_pkg::INDEX_W-1:0]   i_rule_index,
    input  logic [tms_pkg::WORD_W-1:0]    i_rule_word,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tms_pkg::STATE_W-1:0]   o_current_state,
    output logic [tms_pkg::HEAD_W-1:0]    o_head_position,
    output logic [tms_pkg::LEN_W-1:0]     o_ones_count,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tms_pkg::CFG_W-1:0]     i_cfg_data
);
    import tms_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_ACT   = 4'b0100,
        S_MOD   = 4'b1000
    } t_fsm;

    t_fsm               r_fsm;
    logic [HEAD_W-1:0]  r_clr;
    logic [STATE_W-1:0] r_state;
    logic [HEAD_W-1:0]  r_head;
    logic [LEN_W-1:0]   r_ones;
    logic [LEN_W-1:0]   r_len;
    logic [STATE_W-1:0] r_init;

    logic               r_out_valid;
    logic [STATE_W-1:0] r_out_state;
    logic [HEAD_W-1:0]  r_out_head;
    logic [LEN_W-1:0]   r_out_ones;

    logic               in_xfer;
    logic               res_set;
    t_op                op;
    logic               rule_we;
    logic [WORD_W-1:0]  rule_rd;
    logic               tape_we;
    logic [HEAD_W-1:0]  tape_waddr;
    logic               tape_wdata;
    logic               tape_rd;

    logic [WORD_W-1:0]  word;
    logic [7:0]         action;
    logic               new_bit;
    logic               move_up;
    logic [STATE_W-1:0] act_state;
    logic [LEN_W-1:0]   next_ones;
    logic               in_range;
    logic [LEN_W-1:0]   head_inc;
    logic [HEAD_W-1:0]  fast_head;
    logic [DIV_W-1:0]   dividend;

    logic               mod_start;
    logic               mod_done;
    logic [HEAD_W-1:0]  mod_rem;

    assign op         = t_op'(i_op);
    assign o_in_ready = (r_fsm == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // rule table
    assign rule_we = in_xfer && (op == OP_LOAD)
                     && ({1'b0, i_rule_index} < (INDEX_W + 1)'(STATE_COUNT));

    tms_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RULE_DEPTH)
    ) u_rule_ram (
        .i_clk   (i_clk),
        .i_we    (rule_we),
        .i_waddr (i_rule_index),
        .i_wdata (i_rule_word),
        .i_raddr (r_state),
        .o_rdata (rule_rd)
    );

    // tape: clear sweep or step write-back
    always_comb begin
        tape_we    = 1'b0;
        tape_waddr = r_head;
        tape_wdata = new_bit;
        if (r_fsm == S_CLEAR) begin
            tape_we    = 1'b1;
            tape_waddr = r_clr;
            tape_wdata = 1'b0;
        end else if (r_fsm == S_ACT) begin
            tape_we = 1'b1;
        end
    end

    tms_ram #(
        .WIDTH (1),
        .DEPTH (TAPE_DEPTH)
    ) u_tape_ram (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (tape_wdata),
        .i_raddr (r_head),
        .o_rdata (tape_rd)
    );

    // action decode and head move
    always_comb begin
        if ({1'b0, r_state} < (STATE_W + 1)'(STATE_COUNT)) begin
            word = rule_rd;
        end else begin
            word = '0;
        end
        action    = tape_rd ? word[15:8] : word[7:0];
        new_bit   = action[ACT_WRITE_BIT];
        move_up   = action[ACT_MOVE_BIT];
        act_state = action[ACT_STATE_LSB +: STATE_W];

        if (tape_rd && !new_bit) begin
            next_ones = r_ones - 1'b1;
        end else if (!tape_rd && new_bit) begin
            next_ones = r_ones + 1'b1;
        end else begin
            next_ones = r_ones;
        end

        in_range = LEN_W'(r_head) < r_len;
        head_inc = LEN_W'(r_head) + 1'b1;
        if (move_up) begin
            fast_head = (head_inc == r_len) ? '0 : head_inc[HEAD_W-1:0];
        end else if (r_head == '0) begin
            fast_head = HEAD_W'(r_len - 1'b1);
        end else begin
            fast_head = r_head - 1'b1;
        end

        if (move_up) begin
            dividend = DIV_W'(r_head) + DIV_W'(r_len) + 1'b1;
        end else begin
            dividend = DIV_W'(r_head) + DIV_W'(r_len) - 1'b1;
        end
    end

    assign mod_start = (r_fsm == S_ACT) && !in_range;

    tms_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (dividend),
        .i_divisor  (r_len),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // a result is produced by every item except a step still in progress
    assign res_set = ((r_fsm == S_IDLE) && in_xfer && (op != OP_STEP))
                     || ((r_fsm == S_ACT) && in_range)
                     || ((r_fsm == S_MOD) && mod_done);

    // sequencer and machine registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_CLEAR;
            r_clr       <= '0;
            r_state     <= '0;
            r_head      <= '0;
            r_ones      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= res_set || (r_out_valid && !i_out_ready);
            unique case (r_fsm)
                S_CLEAR: begin
                    // counter wraps back to zero on the last cell
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == HEAD_W'(TAPE_DEPTH - 1)) begin
                        r_fsm <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        unique case (op)
                            OP_RESTART: begin
                                r_state <= r_init;
                                r_head  <= '0;
                                r_ones  <= '0;
                                if (r_ones != '0) begin
                                    r_fsm <= S_CLEAR;
                                end
                            end
                            OP_STEP: begin
                                r_fsm <= S_ACT;
                            end
                            OP_LOAD, OP_NOP: begin
                            end
                        endcase
                    end
                end
                S_ACT: begin
                    r_state <= act_state;
                    r_ones  <= next_ones;
                    if (in_range) begin
                        r_head <= fast_head;
                        r_fsm  <= S_IDLE;
                    end else begin
                        r_fsm <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_head <= mod_rem;
                        r_fsm  <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_CLEAR;
                    r_clr <= '0;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if ((r_fsm == S_IDLE) && in_xfer) begin
            if (op == OP_RESTART) begin
                r_out_state <= r_init;
                r_out_head  <= '0;
                r_out_ones  <= '0;
            end else begin
                r_out_state <= r_state;
                r_out_head  <= r_head;
                r_out_ones  <= r_ones;
            end
        end else if ((r_fsm == S_ACT) && in_range) begin
            r_out_state <= act_state;
            r_out_head  <= fast_head;
            r_out_ones  <= next_ones;
        end else if ((r_fsm == S_MOD) && mod_done) begin
            r_out_state <= r_state;
            r_out_head  <= mod_rem;
            r_out_ones  <= r_ones;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_W'(TAPE_DEPTH);
            r_init <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_TAPE_LENGTH) begin
                if (i_cfg_data == '0) begin
                    r_len <= LEN_W'(1);
                end else if (32'(i_cfg_data) > 32'(TAPE_DEPTH)) begin
                    r_len <= LEN_W'(TAPE_DEPTH);
                end else begin
                    r_len <= LEN_W'(i_cfg_data);
                end
            end else if (i_cfg_index == CFG_INITIAL_STATE) begin
                r_init <= i_cfg_data[STATE_W-1:0];
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_current_state = r_out_state;
    assign o_head_position = r_out_head;
    assign o_ones_count    = r_out_ones;

endmodule
